// File: hw/rtl/error_diffusion_dither_core_macros.svh
// ----------------------------------------------------------------------------
// Error diffusion dither core assertion macros
// Shared concurrent assertion forms used by the dither core.
// ----------------------------------------------------------------------------
`ifndef ERROR_DIFFUSION_DITHER_CORE_MACROS_SVH
`define ERROR_DIFFUSION_DITHER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDD_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("dither core check failed");

// The consequent must hold in the cycle after the antecedent.
`define EDD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("dither core check failed");

`endif

// File: hw/rtl/edd_pkg.sv
// ----------------------------------------------------------------------------
// Error diffusion dither package
// Widths, reset values, register indexes and shared types of the core.
// ----------------------------------------------------------------------------
package edd_pkg;

   // Defaults for the top level parameters.
   localparam int MAX_WIDTH_DEF = 2048;
   localparam int FRAC_BITS_DEF = 8;

   // Field widths.
   localparam int PIXEL_W   = 8;
   localparam int LEVEL_W   = 11;
   localparam int LINE_W    = 12;
   localparam int HEIGHT_W  = 16;
   localparam int SPACING_W = 8;

   // Integer part of the rounded magnitude; it never exceeds 383.
   localparam int QUO_W = 10;

   // Error words carry this many bits above the fraction.
   localparam int ERR_INT_W = 12;

   // Output levels are centered here; error is spread in sixteenths.
   localparam int CENTER     = 128;
   localparam int DIFF_SHIFT = 4;

   // Register port.
   localparam int CSR_AW    = 4;
   localparam int CSR_DW    = 32;
   localparam int REG_IDX_W = 2;

   localparam logic [REG_IDX_W-1:0] REG_LINE_WIDTH    = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_FRAME_HEIGHT  = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_LEVEL_SPACING = 2'd2;

   localparam logic [LINE_W-1:0]    LINE_WIDTH_RST    = 12'd640;
   localparam logic [HEIGHT_W-1:0]  FRAME_HEIGHT_RST  = 16'd480;
   localparam logic [SPACING_W-1:0] LEVEL_SPACING_RST = 8'd32;

   // Sequencer states.
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SUM,
      ST_START,
      ST_DIV,
      ST_LVL,
      ST_ERR,
      ST_WB0,
      ST_WB1
   } state_type;

   // Divider status toward the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

// File: hw/rtl/edd_if.sv
// ----------------------------------------------------------------------------
// Error diffusion dither stream interfaces
// Valid/ready channels for input pixels and quantized results.
// ----------------------------------------------------------------------------
interface edd_req_if;
   logic                         valid;
   logic                         ready;
   logic [edd_pkg::PIXEL_W-1:0]  pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface edd_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [edd_pkg::LEVEL_W-1:0] level;
   logic                               row_end;
   logic                               frame_end;

   modport source (output valid, output level, output row_end, output frame_end,
                   input ready);
   modport sink   (input valid, input level, input row_end, input frame_end,
                   output ready);
endinterface

// File: hw/rtl/edd_err_mem.sv
// ----------------------------------------------------------------------------
// Next row error memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module edd_err_mem #(
   parameter int DEPTH = edd_pkg::MAX_WIDTH_DEF,
   parameter int AW    = $clog2(edd_pkg::MAX_WIDTH_DEF),
   parameter int DW    = edd_pkg::FRAC_BITS_DEF + edd_pkg::ERR_INT_W
) (
   input  logic          clock,
   input  logic          we,
   input  logic [AW-1:0] waddr,
   input  logic [DW-1:0] wdata,
   input  logic [AW-1:0] raddr,
   output logic [DW-1:0] rdata
);

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rdata_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/edd_div.sv
// ----------------------------------------------------------------------------
// Quantizer divider
// Restoring divider, one quotient bit per cycle, for the level index.
// ----------------------------------------------------------------------------
module edd_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [edd_pkg::QUO_W-1:0]       dividend,
   input  logic [edd_pkg::SPACING_W-1:0]   divisor,
   output edd_pkg::div_stat_type           stat,
   output logic [edd_pkg::QUO_W-1:0]       quotient
);

   localparam int QW    = edd_pkg::QUO_W;
   localparam int SW    = edd_pkg::SPACING_W;
   localparam int CNT_W = $clog2(QW);

   logic [SW-1:0]    rem_ff, rem_in;
   logic [QW-1:0]    dvd_ff, dvd_in;
   logic [QW-1:0]    quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [SW:0] trial;
   logic [SW:0] diff;
   logic        fits;

   // One restoring step: shift in the next dividend bit and try a subtract.
   always_comb begin
      trial = {rem_ff, dvd_ff[QW-1]};
      diff  = trial - {1'b0, divisor};
      fits  = (trial >= {1'b0, divisor});

      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;

      if (start) begin
         rem_in  = '0;
         dvd_in  = dividend;
         quo_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[SW-1:0] : trial[SW-1:0];
         dvd_in = {dvd_ff[QW-2:0], 1'b0};
         quo_in = {quo_ff[QW-2:0], fits};
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign quotient  = quo_ff;

endmodule

// File: hw/rtl/error_diffusion_dither_core.sv
// ----------------------------------------------------------------------------
// Error diffusion dither core
// Floyd-Steinberg error diffusion of one channel, one pixel per item.
// ----------------------------------------------------------------------------
// Usage:
//   Pixels enter on req_ch in raster order; each gives one item on rsp_ch
//   carrying the quantized level and row and frame end flags. The line
//   width, frame height and level spacing are to be written through the
//   APB port while the core is idle; the core does not enforce this.
//   An item's result is set by the sequencer: the error memory read issues
//   at acceptance, then one sum, one divider start, the level divider (ten
//   restoring steps, then its done flag), then level, error and write-back
//   steps. A new item is taken once the previous one has left write-back,
//   which takes a second write step when the error for the previous
//   column must also be written; the single write port of the error
//   memory takes the two writes in turn.
//   After reset the error memory is cleared, one entry a cycle, through all
//   MAX_WIDTH entries; no item is taken until then, while register writes
//   are taken at any time.
//   The result register holds one finished item. A stalled receiver holds
//   the core in its write-back step until the waiting item is taken; the
//   next input item may be accepted while a result is waiting.
// ----------------------------------------------------------------------------
`include "error_diffusion_dither_core_macros.svh"

module error_diffusion_dither_core #(
   parameter int MAX_WIDTH = edd_pkg::MAX_WIDTH_DEF,
   parameter int FRAC_BITS = edd_pkg::FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   edd_req_if.sink                     req_ch,
   edd_rsp_if.source                   rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [edd_pkg::CSR_AW-1:0]  paddr,
   input  logic [edd_pkg::CSR_DW-1:0]  pwdata,
   output logic [edd_pkg::CSR_DW-1:0]  prdata,
   output logic                        pready
);

   localparam int AW    = $clog2(MAX_WIDTH);
   localparam int WW    = (AW + 1 > edd_pkg::LINE_W) ? AW + 1 : edd_pkg::LINE_W;
   localparam int ERR_W = FRAC_BITS + edd_pkg::ERR_INT_W;
   localparam int PW    = edd_pkg::PIXEL_W;
   localparam int LW    = edd_pkg::LEVEL_W;
   localparam int QW    = edd_pkg::QUO_W;
   localparam int SW    = edd_pkg::SPACING_W;
   localparam int HW    = edd_pkg::HEIGHT_W;
   localparam int DS    = edd_pkg::DIFF_SHIFT;

   localparam logic [WW-1:0]           MAXW      = WW'(MAX_WIDTH);
   localparam logic [AW-1:0]           LAST_ADDR = AW'(MAX_WIDTH - 1);
   localparam logic signed [ERR_W-1:0] CENTER_FX =
      ERR_W'(edd_pkg::CENTER * (2 ** FRAC_BITS));
   localparam logic signed [LW-1:0]    CENTER_LV = LW'(edd_pkg::CENTER);
   localparam logic signed [ERR_W-1:0] TRUNC_BIAS = ERR_W'((2 ** DS) - 1);

   // Registers.
   edd_pkg::state_type state_ff, state_in;

   logic [edd_pkg::LINE_W-1:0] line_width_ff, line_width_in;
   logic [HW-1:0]              frame_height_ff, frame_height_in;
   logic [SW-1:0]              level_spacing_ff, level_spacing_in;

   logic [AW-1:0]           clr_ff, clr_in;
   logic [AW-1:0]           column_ff, column_in;
   logic [HW-1:0]           row_ff, row_in;
   logic signed [ERR_W-1:0] rc_ff, rc_in;
   logic signed [ERR_W-1:0] pl_ff, pl_in;
   logic signed [ERR_W-1:0] pr_ff, pr_in;

   logic [PW-1:0]           pixel_ff, pixel_in;
   logic [AW-1:0]           col_ff, col_in;
   logic                    last_col_ff, last_col_in;
   logic                    last_row_ff, last_row_in;
   logic signed [ERR_W-1:0] sum_ff, sum_in;
   logic                    neg_ff, neg_in;
   logic signed [LW-1:0]    lev_ff, lev_in;
   logic signed [ERR_W-1:0] v_ff, v_in;
   logic signed [ERR_W-1:0] nb_ff, nb_in;

   logic                    out_valid_ff, out_valid_in;
   logic signed [LW-1:0]    out_level_ff, out_level_in;
   logic                    out_row_end_ff, out_row_end_in;
   logic                    out_frame_end_ff, out_frame_end_in;

   // Memory and divider connections.
   logic             mem_we;
   logic [AW-1:0]    mem_waddr;
   logic [ERR_W-1:0] mem_wdata;
   logic [AW-1:0]    mem_raddr;
   logic [ERR_W-1:0] mem_rdata;

   logic                  div_start;
   logic [QW-1:0]         div_dividend;
   edd_pkg::div_stat_type div_stat;
   logic [QW-1:0]         div_quotient;

   // Working values.
   logic                    csr_wr;
   logic [edd_pkg::REG_IDX_W-1:0] csr_idx;
   logic [WW-1:0]           w_eff;
   logic [AW-1:0]           last_idx;
   logic [AW-1:0]           col_now;
   logic [HW-1:0]           h_last;
   logic [SW-1:0]           s_eff;
   logic signed [ERR_W-1:0] pix_fx;
   logic signed [ERR_W-1:0] d_val;
   logic [ERR_W-1:0]        mag;
   logic [ERR_W-1:0]        rounded;
   logic [QW+SW-1:0]        qs;
   logic signed [ERR_W-1:0] lev_fx;
   logic signed [ERR_W-1:0] e_val;
   logic signed [ERR_W-1:0] e_adj;
   logic signed [ERR_W-1:0] v3;
   logic signed [ERR_W-1:0] v5;
   logic signed [ERR_W-1:0] v7;
   logic signed [ERR_W-1:0] pl_new;

   edd_err_mem #(
      .DEPTH (MAX_WIDTH),
      .AW    (AW),
      .DW    (ERR_W)
   ) u_err_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   edd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (s_eff),
      .stat     (div_stat),
      .quotient (div_quotient)
   );

   // Register port: always ready, write on the access phase.
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_idx = paddr[edd_pkg::CSR_AW-1:2];

   always_comb begin
      unique case (csr_idx)
         edd_pkg::REG_LINE_WIDTH:    prdata = edd_pkg::CSR_DW'(line_width_ff);
         edd_pkg::REG_FRAME_HEIGHT:  prdata = edd_pkg::CSR_DW'(frame_height_ff);
         edd_pkg::REG_LEVEL_SPACING: prdata = edd_pkg::CSR_DW'(level_spacing_ff);
         default:                    prdata = '0;
      endcase
   end

   // Effective geometry and spacing, with zero and oversize values clamped.
   always_comb begin
      w_eff = (line_width_ff == '0) ? WW'(1) : WW'(line_width_ff);
      if (w_eff > MAXW) begin
         w_eff = MAXW;
      end
      last_idx = AW'(w_eff - WW'(1));
      col_now  = (column_ff > last_idx) ? last_idx : column_ff;
      h_last   = (frame_height_ff == '0) ? '0 : frame_height_ff - HW'(1);
      s_eff    = (level_spacing_ff == '0) ? SW'(1) : level_spacing_ff;
   end

   // Quantizer arithmetic.
   always_comb begin
      pix_fx  = $signed({{(ERR_W - PW - FRAC_BITS){1'b0}}, pixel_ff,
                         {FRAC_BITS{1'b0}}});
      d_val   = sum_ff - CENTER_FX;
      mag     = d_val[ERR_W-1] ? ERR_W'(-d_val) : ERR_W'(d_val);
      rounded = mag + (ERR_W'(s_eff) << (FRAC_BITS - 1));
      div_dividend = rounded[FRAC_BITS +: QW];

      qs = div_quotient * s_eff;

      lev_fx = $signed({{(ERR_W - LW){lev_ff[LW-1]}}, lev_ff}) <<< FRAC_BITS;
      e_val  = sum_ff - lev_fx;
      // Divide by sixteen, truncating toward zero.
      e_adj  = e_val[ERR_W-1] ? e_val + TRUNC_BIAS : e_val;

      v3     = v_ff + (v_ff <<< 1);
      v5     = v_ff + (v_ff <<< 2);
      v7     = (v_ff <<< 3) - v_ff;
      pl_new = pr_ff + v5;
   end

   // Sequencer: next state, datapath updates and memory accesses.
   always_comb begin
      state_in         = state_ff;
      line_width_in    = line_width_ff;
      frame_height_in  = frame_height_ff;
      level_spacing_in = level_spacing_ff;
      clr_in           = clr_ff;
      column_in        = column_ff;
      row_in           = row_ff;
      rc_in            = rc_ff;
      pl_in            = pl_ff;
      pr_in            = pr_ff;
      pixel_in         = pixel_ff;
      col_in           = col_ff;
      last_col_in      = last_col_ff;
      last_row_in      = last_row_ff;
      sum_in           = sum_ff;
      neg_in           = neg_ff;
      lev_in           = lev_ff;
      v_in             = v_ff;
      nb_in            = nb_ff;
      out_valid_in     = out_valid_ff && !rsp_ch.ready;
      out_level_in     = out_level_ff;
      out_row_end_in   = out_row_end_ff;
      out_frame_end_in = out_frame_end_ff;

      req_ch.ready = 1'b0;
      div_start    = 1'b0;
      mem_we       = 1'b0;
      mem_waddr    = col_ff;
      mem_wdata    = '0;
      mem_raddr    = col_now;

      // Register writes are taken in any state.
      if (csr_wr) begin
         unique case (csr_idx)
            edd_pkg::REG_LINE_WIDTH:    line_width_in    = pwdata[edd_pkg::LINE_W-1:0];
            edd_pkg::REG_FRAME_HEIGHT:  frame_height_in  = pwdata[HW-1:0];
            edd_pkg::REG_LEVEL_SPACING: level_spacing_in = pwdata[SW-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         // Zero the error memory after reset.
         edd_pkg::ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == LAST_ADDR) begin
               state_in = edd_pkg::ST_IDLE;
            end
         end

         // Take an item; the memory read of its column issues now.
         edd_pkg::ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               pixel_in    = req_ch.pixel;
               col_in      = col_now;
               last_col_in = (col_now == last_idx);
               last_row_in = (row_ff >= h_last);
               state_in    = edd_pkg::ST_SUM;
            end
         end

         // Pixel plus the error from above and from the left.
         edd_pkg::ST_SUM: begin
            sum_in   = pix_fx + $signed(mem_rdata) + rc_ff;
            state_in = edd_pkg::ST_START;
         end

         // Start the level divider on the rounded magnitude.
         edd_pkg::ST_START: begin
            div_start = 1'b1;
            neg_in    = d_val[ERR_W-1];
            state_in  = edd_pkg::ST_DIV;
         end

         edd_pkg::ST_DIV: begin
            if (div_stat.done) begin
               state_in = edd_pkg::ST_LVL;
            end
         end

         // Output level around the center.
         edd_pkg::ST_LVL: begin
            lev_in   = neg_ff ? CENTER_LV - $signed({1'b0, qs[LW-2:0]})
                              : CENTER_LV + $signed({1'b0, qs[LW-2:0]});
            state_in = edd_pkg::ST_ERR;
         end

         // One sixteenth of the quantization error.
         edd_pkg::ST_ERR: begin
            v_in     = e_adj >>> DS;
            state_in = edd_pkg::ST_WB0;
         end

         // Write this column back, update carries, post the result.
         edd_pkg::ST_WB0: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               mem_we    = 1'b1;
               mem_waddr = col_ff;
               mem_wdata = (last_col_ff && !last_row_ff) ? ERR_W'(pl_new) : '0;
               nb_in     = pl_ff + v3;
               rc_in     = last_col_ff ? '0 : v7;
               if (!last_row_ff) begin
                  pl_in = last_col_ff ? '0 : pl_new;
                  pr_in = last_col_ff ? '0 : v_ff;
               end else begin
                  pl_in = '0;
                  pr_in = '0;
               end

               out_valid_in     = 1'b1;
               out_level_in     = lev_ff;
               out_row_end_in   = last_col_ff;
               out_frame_end_in = last_col_ff && last_row_ff;

               if (last_col_ff) begin
                  column_in = '0;
                  row_in    = last_row_ff ? '0 : row_ff + 1'b1;
               end else begin
                  column_in = col_ff + 1'b1;
               end

               state_in = (!last_row_ff && col_ff != '0) ? edd_pkg::ST_WB1
                                                         : edd_pkg::ST_IDLE;
            end
         end

         // Down-left share for the previous column.
         edd_pkg::ST_WB1: begin
            mem_we    = 1'b1;
            mem_waddr = col_ff - 1'b1;
            mem_wdata = ERR_W'(nb_ff);
            state_in  = edd_pkg::ST_IDLE;
         end

         default: begin
            state_in = edd_pkg::ST_IDLE;
         end
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= edd_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control and configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff    <= edd_pkg::LINE_WIDTH_RST;
         frame_height_ff  <= edd_pkg::FRAME_HEIGHT_RST;
         level_spacing_ff <= edd_pkg::LEVEL_SPACING_RST;
         clr_ff           <= '0;
         column_ff        <= '0;
         row_ff           <= '0;
         rc_ff            <= '0;
         pl_ff            <= '0;
         pr_ff            <= '0;
         out_valid_ff     <= 1'b0;
      end else begin
         line_width_ff    <= line_width_in;
         frame_height_ff  <= frame_height_in;
         level_spacing_ff <= level_spacing_in;
         clr_ff           <= clr_in;
         column_ff        <= column_in;
         row_ff           <= row_in;
         rc_ff            <= rc_in;
         pl_ff            <= pl_in;
         pr_ff            <= pr_in;
         out_valid_ff     <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      pixel_ff         <= pixel_in;
      col_ff           <= col_in;
      last_col_ff      <= last_col_in;
      last_row_ff      <= last_row_in;
      sum_ff           <= sum_in;
      neg_ff           <= neg_in;
      lev_ff           <= lev_in;
      v_ff             <= v_in;
      nb_ff            <= nb_in;
      out_level_ff     <= out_level_in;
      out_row_end_ff   <= out_row_end_in;
      out_frame_end_ff <= out_frame_end_in;
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.level     = out_level_ff;
   assign rsp_ch.row_end   = out_row_end_ff;
   assign rsp_ch.frame_end = out_frame_end_ff;

   // Checks on the sequencer.
   `EDD_ASSERT_NOW(a_clear_blocks_items, clock, reset, state_ff == edd_pkg::ST_CLEAR, mem_we && !req_ch.ready)
   `EDD_ASSERT_NOW(a_div_done_in_wait, clock, reset, div_stat.done, state_ff == edd_pkg::ST_DIV)
   `EDD_ASSERT_NOW(a_left_write_valid, clock, reset, state_ff == edd_pkg::ST_WB1, col_ff != '0 && !last_row_ff)
   `EDD_ASSERT_NEXT(a_accept_reads_sum, clock, reset, req_ch.valid && req_ch.ready, state_ff == edd_pkg::ST_SUM && !div_stat.busy)

endmodule

// File: test/error_diffusion_dither_core_test.sv
// ----------------------------------------------------------------------------
// Error diffusion dither core testbench
// Streams pixels through the core under changing line width, frame height and
// level spacing, with random gaps on both channels. Every result item is
// checked field by field against a dither predictor, or a typed-in result
// where marked. A short directed table runs first, then random frame phases.
// ----------------------------------------------------------------------------
module error_diffusion_dither_core_test;
   import edd_pkg::*;

   localparam int MAXW          = MAX_WIDTH_DEF;
   localparam int ONE           = 1 << FRAC_BITS_DEF;
   localparam int DIFF_DIV      = 1 << DIFF_SHIFT;
   localparam int SETTLE_CYCLES = 24;
   localparam int IDLE_PERCENT  = 38;
   localparam int RANDOM_ITEMS  = 1880;
   localparam int DIR_ROWS      = 28;
   localparam int TIMEOUT       = 10_000_000;

   // One result item as it leaves the core.
   typedef struct packed {
      logic signed [LEVEL_W-1:0] level;
      logic                      row_end;
      logic                      frame_end;
   } level_item_t;

   typedef enum logic {
      STEP_PIXEL,
      STEP_WRITE
   } step_kind_t;

   // One row of the directed table; the result is typed in only where marked.
   typedef struct packed {
      step_kind_t                kind;
      logic [REG_IDX_W-1:0]      idx;
      logic [CSR_DW-1:0]         value;
      logic [PIXEL_W-1:0]        pixel;
      logic                      typed;
      logic signed [LEVEL_W-1:0] level;
      logic                      row_end;
      logic                      frame_end;
   } dither_step_t;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 pix_valid = 1'b0;
   logic [PIXEL_W-1:0]   pix_data  = '0;
   logic                 level_ready = 1'b0;

   logic                 psel    = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite  = 1'b0;
   logic [CSR_AW-1:0]    paddr   = '0;
   logic [CSR_DW-1:0]    pwdata  = '0;
   logic [CSR_DW-1:0]    prdata;
   logic                 pready;

   bit steady = 1'b0;
   int mismatch_count = 0;

   level_item_t  expected_levels [$];
   dither_step_t directed [DIR_ROWS];

   // Predictor copy of the registers and the diffusion state.
   logic [LINE_W-1:0]    cfg_width   = LINE_WIDTH_RST;
   logic [HEIGHT_W-1:0]  cfg_height  = FRAME_HEIGHT_RST;
   logic [SPACING_W-1:0] cfg_spacing = LEVEL_SPACING_RST;
   int err_below [MAXW];
   int err_right    = 0;
   int gather_left  = 0;
   int gather_right = 0;
   int col_pos      = 0;
   int row_pos      = 0;

   edd_req_if req_if ();
   edd_rsp_if rsp_if ();

   assign req_if.valid = pix_valid;
   assign req_if.pixel = pix_data;
   assign rsp_if.ready = level_ready;

   error_diffusion_dither_core i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always #10 clock = ~clock;

   // Quantize one pixel and spread its error, as the core should.
   task automatic predict_level(input logic [PIXEL_W-1:0] px, output level_item_t res);
      int w, h, s, col, sum, d, mag, sp, q, lvl, e, v;
      bit last_col, last_row;
      w = int'(cfg_width);
      if (w == 0) w = 1;
      if (w > MAXW) w = MAXW;
      h = (cfg_height == 0) ? 1 : int'(cfg_height);
      s = (cfg_spacing == 0) ? 1 : int'(cfg_spacing);
      // A position left beyond a shrunk frame counts as the last one.
      col = (col_pos > w - 1) ? w - 1 : col_pos;
      last_col = (col == w - 1);
      last_row = (row_pos >= h - 1);

      sum = int'(px) * ONE + err_below[col] + err_right;
      err_below[col] = 0;

      // Round half away from zero around the center level.
      d = sum - CENTER * ONE;
      mag = (d < 0) ? -d : d;
      sp = s * ONE;
      q = (mag + sp / 2) / sp;
      if (d < 0) q = -q;
      lvl = q * s + CENTER;
      e = sum - lvl * ONE;
      v = e / DIFF_DIV;

      err_right = last_col ? 0 : 7 * v;

      // The bottom row sends error only to the right.
      if (!last_row) begin
         if (col > 0) err_below[col - 1] = gather_left + 3 * v;
         gather_left = gather_right + 5 * v;
         gather_right = last_col ? 0 : v;
         if (last_col) begin
            err_below[col] = gather_left;
            gather_left = 0;
         end
      end else begin
         gather_left = 0;
         gather_right = 0;
      end

      res.level = lvl[LEVEL_W-1:0];
      res.row_end = last_col;
      res.frame_end = last_col && last_row;

      if (last_col) begin
         col_pos = 0;
         row_pos = last_row ? 0 : row_pos + 1;
      end else begin
         col_pos = col + 1;
      end
   endtask

   // Offer one pixel after a random gap and record what it should produce.
   task automatic send_pixel(input logic [PIXEL_W-1:0] px, input bit typed,
                             input level_item_t want);
      level_item_t pred;
      while (!steady && $urandom_range(0, 99) < IDLE_PERCENT) begin
         pix_valid <= 1'b0;
         @(posedge clock);
      end
      pix_valid <= 1'b1;
      pix_data <= px;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      predict_level(px, pred);
      expected_levels.push_back(typed ? want : pred);
   endtask

   // Hold the sender off until every result is back and the core is quiet.
   task automatic drain_levels();
      pix_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup cycle, then access cycle; pready is always high.
   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DW-1:0] val);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_LINE_WIDTH:    cfg_width = val[LINE_W-1:0];
         REG_FRAME_HEIGHT:  cfg_height = val[HEIGHT_W-1:0];
         REG_LEVEL_SPACING: cfg_spacing = val[SPACING_W-1:0];
         default: ;
      endcase
   endtask

   // Result side: random back-pressure and the check against the oldest expectation.
   always @(posedge clock) begin
      level_item_t want;
      level_ready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
      if (!reset && rsp_if.valid && level_ready) begin
         if (expected_levels.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected result item: level %0d row_end %0b frame_end %0b",
                        rsp_if.level, rsp_if.row_end, rsp_if.frame_end);
         end else begin
            want = expected_levels.pop_front();
            if (rsp_if.level !== want.level || rsp_if.row_end !== want.row_end ||
                rsp_if.frame_end !== want.frame_end) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("result mismatch: level exp %0d got %0d, row_end exp %0b got %0b, frame_end exp %0b got %0b",
                           want.level, rsp_if.level, want.row_end, rsp_if.row_end,
                           want.frame_end, rsp_if.frame_end);
            end
         end
      end
   end

   initial begin
      #(TIMEOUT);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      level_item_t want;
      int sent, phase, n, style, tmp;
      logic [PIXEL_W-1:0] px, base, stride;

      foreach (err_below[i]) err_below[i] = 0;

      // Directed items: reset defaults, mid-frame shrink, and the register extremes.
      directed = '{
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd128, 1'b1,  11'sd128, 1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd255, 1'b1,  11'sd256, 1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd0,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_WRITE, REG_LINE_WIDTH,    32'd2,    8'd0,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd77,  1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd200, 1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_WRITE, REG_FRAME_HEIGHT,  32'd1,    8'd0,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_WRITE, REG_LINE_WIDTH,    32'd1,    8'd0,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_WRITE, REG_LEVEL_SPACING, 32'd255,  8'd0,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd128, 1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd0,   1'b1, -11'sd127, 1'b1, 1'b1},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd255, 1'b1,  11'sd128, 1'b1, 1'b1},
         '{STEP_WRITE, REG_LEVEL_SPACING, 32'd0,    8'd0,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd0,   1'b1,  11'sd0,   1'b1, 1'b1},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd255, 1'b1,  11'sd255, 1'b1, 1'b1},
         '{STEP_WRITE, REG_LEVEL_SPACING, 32'd2,    8'd0,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd127, 1'b1,  11'sd126, 1'b1, 1'b1},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd129, 1'b1,  11'sd130, 1'b1, 1'b1},
         '{STEP_WRITE, REG_FRAME_HEIGHT,  32'd0,    8'd0,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd200, 1'b1,  11'sd200, 1'b1, 1'b1},
         '{STEP_WRITE, REG_LINE_WIDTH,    32'd0,    8'd0,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd55,  1'b1,  11'sd54,  1'b1, 1'b1},
         '{STEP_WRITE, REG_LINE_WIDTH,    32'd4095, 8'd0,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_WRITE, REG_FRAME_HEIGHT,  32'd2,    8'd0,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_WRITE, REG_LEVEL_SPACING, 32'd32,   8'd0,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd255, 1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd3,   1'b0,  11'sd0,   1'b0, 1'b0},
         '{STEP_PIXEL, REG_LINE_WIDTH,    32'd0,    8'd128, 1'b0,  11'sd0,   1'b0, 1'b0}
      };

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // The core clears its error memory first; the handshake waits it out.
      foreach (directed[i]) begin
         if (directed[i].kind == STEP_WRITE) begin
            drain_levels();
            csr_write(directed[i].idx, directed[i].value);
         end else begin
            want.level = directed[i].level;
            want.row_end = directed[i].row_end;
            want.frame_end = directed[i].frame_end;
            send_pixel(directed[i].pixel, directed[i].typed, want);
         end
      end

      // Random phases: a new setting, then a run of pixels that often spans frames.
      sent = 0;
      phase = 0;
      want = '0;
      while (sent < RANDOM_ITEMS) begin
         drain_levels();
         case ($urandom_range(0, 9))
            0: csr_write(REG_LINE_WIDTH, 32'd0);
            1: csr_write(REG_LINE_WIDTH, 32'd1);
            2: csr_write(REG_LINE_WIDTH, 32'd2048);
            3: csr_write(REG_LINE_WIDTH, 32'd4095);
            default: csr_write(REG_LINE_WIDTH, $urandom_range(2, 24));
         endcase
         case ($urandom_range(0, 9))
            0: csr_write(REG_FRAME_HEIGHT, 32'd0);
            1: csr_write(REG_FRAME_HEIGHT, 32'd1);
            2: csr_write(REG_FRAME_HEIGHT, 32'd65535);
            default: csr_write(REG_FRAME_HEIGHT, $urandom_range(2, 8));
         endcase
         case ($urandom_range(0, 9))
            0: csr_write(REG_LEVEL_SPACING, 32'd0);
            1: csr_write(REG_LEVEL_SPACING, 32'd1);
            2: csr_write(REG_LEVEL_SPACING, 32'd255);
            default: csr_write(REG_LEVEL_SPACING, $urandom_range(1, 255));
         endcase

         n = $urandom_range(20, 160);
         style = $urandom_range(0, 3);
         base = $urandom_range(0, 255);
         stride = $urandom_range(0, 255);
         steady = (phase == 4);
         for (int i = 0; i < n; i++) begin
            case (style)
               0: tmp = $urandom_range(0, 255);
               1: tmp = ($urandom_range(0, 1) != 0) ? 255 : 0;
               2: tmp = int'(base) + i * int'(stride);
               default: tmp = int'(base) + $urandom_range(0, 6) - 3;
            endcase
            px = tmp[PIXEL_W-1:0];
            // Once, let the pipeline run empty in the middle of a frame.
            if (phase == 2 && i == n / 2) drain_levels();
            send_pixel(px, 1'b0, want);
            sent++;
         end
         phase++;
      end
      steady = 1'b0;

      pix_valid <= 1'b0;
      while (expected_levels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && expected_levels.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
